/* src/qphc_pkg.sv */
// ----------------------------------------------------------------------------
// qphc_pkg
// Shared types and constants for the quadratic probe hash cache.
// ----------------------------------------------------------------------------
package qphc_pkg;

  // Table size, a power of two, so every modulo in the probe path is a mask
  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  localparam int KEY_W  = 32;
  localparam int DIM_W  = 16;
  localparam int SLOT_W = 12;
  localparam int STAT_W = 3;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t ST_HIT         = 3'd0;
  localparam status_t ST_INSERTED    = 3'd1;
  localparam status_t ST_LOAD_FAILED = 3'd2;
  localparam status_t ST_FULL        = 3'd3;
  localparam status_t ST_FREED       = 3'd4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* src/qphc_ram.sv */
// ----------------------------------------------------------------------------
// qphc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module qphc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/quadratic_probe_hash_cache.sv */
// ----------------------------------------------------------------------------
// quadratic_probe_hash_cache
// Open-addressed cache of image sizes keyed by a 32-bit hash, quadratic probing.
// ----------------------------------------------------------------------------
// After reset the block sweeps the table memory to clear every valid mark,
// one slot per cycle; req_ready stays low meanwhile. A free clears the given
// slot, if it lies in the table, once the output register is free. A load
// probes up to TABLE_ENTRIES slots, one after another; the probe walk is bound
// by the single read port of the table memory, which delivers one slot per
// cycle. One word is worked on at a time; a finished result waits in the
// output register while the next request word is taken and probed.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_cache (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic                      cmd,
  input  logic [qphc_pkg::KEY_W-1:0]  key,
  input  logic                      image_ok,
  input  logic [qphc_pkg::DIM_W-1:0]  image_width,
  input  logic [qphc_pkg::DIM_W-1:0]  image_height,
  input  logic [qphc_pkg::SLOT_W-1:0] free_index,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output qphc_pkg::status_t         status,
  output logic [qphc_pkg::SLOT_W-1:0] slot_index,
  output logic [qphc_pkg::DIM_W-1:0]  out_width,
  output logic [qphc_pkg::DIM_W-1:0]  out_height
);

  import qphc_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;
  localparam logic [1:0] S_FREE  = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [1:0]        state;
  logic [IDX_W-1:0]  clr_cnt;
  logic [IDX_W-1:0]  slot;
  logic [IDX_W-1:0]  step;
  logic [IDX_W-1:0]  cnt;

  logic [KEY_W-1:0]  key_q;
  logic              ok_q;
  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  height_q;
  logic [SLOT_W-1:0] free_q;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd;

  logic              req_fire;
  logic              out_free;
  logic              is_empty;
  logic              is_match;
  logic              probe_done;
  logic [IDX_W-1:0]  slot_next;
  logic              free_in_range;

  assign rd        = entry_t'(ram_rdata);
  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  assign is_empty   = !rd.valid;
  assign is_match   = rd.key == key_q;
  assign probe_done = is_empty || is_match || (cnt == LAST_IDX);
  // next quadratic slot: s(i+1) = s(i) + 2i + 1, mod table size
  assign slot_next  = slot + step;

  assign free_in_range = 32'(free_q) < 32'(TABLE_ENTRIES);

  qphc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = slot_next;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      S_IDLE: begin
        ram_re    = req_fire && (cmd == CMD_LOAD);
        ram_raddr = key[IDX_W-1:0];
      end
      S_PROBE: begin
        if (!probe_done) begin
          ram_re = 1'b1;
        end else if (out_free && is_empty && ok_q) begin
          ram_we    = 1'b1;
          ram_wdata = '{valid: 1'b1, key: key_q, width: width_q, height: height_q};
        end
      end
      S_FREE: begin
        ram_we    = out_free && free_in_range;
        ram_waddr = IDX_W'(free_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            state <= (cmd == CMD_FREE) ? S_FREE : S_PROBE;
          end
        end
        S_PROBE: begin
          if (probe_done && out_free) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_FREE: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_fire) begin
      key_q    <= key;
      ok_q     <= image_ok;
      width_q  <= image_width;
      height_q <= image_height;
      free_q   <= free_index;
      slot     <= key[IDX_W-1:0];
      step     <= IDX_W'(1);
      cnt      <= '0;
    end else if (state == S_PROBE && !probe_done) begin
      slot <= slot_next;
      step <= step + IDX_W'(2);
      cnt  <= cnt + 1'b1;
    end

    if (state == S_PROBE && probe_done && out_free) begin
      if (is_empty) begin
        status     <= ok_q ? ST_INSERTED : ST_LOAD_FAILED;
        slot_index <= ok_q ? SLOT_W'(slot) : '0;
        out_width  <= ok_q ? width_q : '0;
        out_height <= ok_q ? height_q : '0;
      end else if (is_match) begin
        status     <= ST_HIT;
        slot_index <= SLOT_W'(slot);
        out_width  <= rd.width;
        out_height <= rd.height;
      end else begin
        status     <= ST_FULL;
        slot_index <= '0;
        out_width  <= '0;
        out_height <= '0;
      end
    end else if (state == S_FREE && out_free) begin
      status     <= ST_FREED;
      slot_index <= free_q;
      out_width  <= '0;
      out_height <= '0;
    end
  end

  // a table write during a probe is only ever an insert into an empty slot
  a_probe_write_insert: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE && ram_we) |-> (is_empty && ok_q && out_free))
    else $error("table write during probe without insert");

  // a load word always starts a probe walk
  a_load_starts_probe: assert property (@(posedge clk) disable iff (rst)
    (req_fire && cmd == CMD_LOAD) |=> (state == S_PROBE))
    else $error("load word did not start probing");

  // failed and full results carry no slot and no sizes
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status == ST_LOAD_FAILED || status == ST_FULL)) |->
      (slot_index == '0 && out_width == '0 && out_height == '0))
    else $error("failed or full result carries data");

  // nothing is reported while the clearing sweep runs
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!rsp_valid && !ram_re))
    else $error("activity during clearing sweep");

endmodule
